// ===== rtl/info_frame_stuffing_framer_core_defines.svh =====
// assertion macros shared by the framer
`ifndef INFO_FRAME_STUFFING_FRAMER_CORE_DEFINES_SVH
`define INFO_FRAME_STUFFING_FRAMER_CORE_DEFINES_SVH

// same-cycle implication, checked after reset
`define IFSF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ifsf assertion failed");

// next-cycle implication, checked after reset
`define IFSF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ifsf assertion failed");

`endif

// ===== rtl/ifsf_pkg.sv =====
package ifsf_pkg;

    localparam int CMD_DEPTH_DEF = 4;
    localparam int SEQ_SHIFT     = 6;
    localparam int REG_IDX_W     = 3;
    localparam int PADDR_W       = 5;

    localparam logic [REG_IDX_W-1:0] REG_FLAG    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ESCAPE  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_MASK    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ADDRESS = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_CONTROL = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_MAX_PAY = 3'd5;

    localparam logic [7:0]  FLAG_RST    = 8'h7E;
    localparam logic [7:0]  ESCAPE_RST  = 8'h7D;
    localparam logic [7:0]  MASK_RST    = 8'h20;
    localparam logic [7:0]  ADDRESS_RST = 8'h03;
    localparam logic [7:0]  CONTROL_RST = 8'h00;
    localparam logic [15:0] MAX_PAY_RST = 16'd1024;

    typedef struct packed {
        logic [7:0]  flag_value;
        logic [7:0]  escape_value;
        logic [7:0]  stuff_mask;
        logic [7:0]  address_value;
        logic [7:0]  control_base;
        logic [15:0] max_payload;
    } t_cfg;

    typedef struct packed {
        logic [7:0] data;
        logic [7:0] ctrl;
        logic [7:0] check;
        logic       open;
        logic       close;
        logic       abort;
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_OPEN_FLAG,
        ST_ADDR,
        ST_CTRL,
        ST_HCHK,
        ST_DATA,
        ST_PCHK,
        ST_CLOSE_FLAG,
        ST_ABORT
    } t_state;

endpackage

// ===== rtl/ifsf_cmd_fifo.sv =====
module ifsf_cmd_fifo import ifsf_pkg::*; #(
    parameter int DEPTH = CMD_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/ifsf_front.sv =====
module ifsf_front import ifsf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    input  logic       i_seq_bit,
    input  logic       i_last_byte,
    output logic       o_push,
    output t_cmd       o_cmd
);

    logic        r_in_frame;
    logic [7:0]  r_check;
    logic [15:0] r_count;
    logic        r_discarding;
    logic        n_in_frame;
    logic [7:0]  n_check;
    logic [15:0] n_count;
    logic        n_discarding;
    logic [16:0] new_count;
    logic        too_long;
    logic [7:0]  new_check;
    logic [7:0]  seq_byte;

    assign new_count = r_in_frame ? ({1'b0, r_count} + 17'd1) : 17'd1;
    assign too_long  = new_count > {1'b0, i_cfg.max_payload};
    assign new_check = (r_in_frame ? r_check : 8'h00) ^ i_data_byte;
    assign seq_byte  = 8'({7'b0, i_seq_bit} << SEQ_SHIFT);

    always_comb begin
        o_cmd.data  = i_data_byte;
        o_cmd.ctrl  = i_cfg.control_base | seq_byte;
        o_cmd.check = new_check;
        o_cmd.open  = !r_in_frame;
        o_cmd.close = i_last_byte;
        o_cmd.abort = too_long;
    end

    assign o_push = i_accept && !r_discarding;

    always_comb begin
        n_in_frame   = r_in_frame;
        n_check      = r_check;
        n_count      = r_count;
        n_discarding = r_discarding;
        if (i_accept) begin
            if (r_discarding) begin
                if (i_last_byte) begin
                    n_discarding = 1'b0;
                end
            end else if (too_long) begin
                n_in_frame   = 1'b0;
                n_check      = 8'h00;
                n_count      = 16'd0;
                n_discarding = !i_last_byte;
            end else if (i_last_byte) begin
                n_in_frame = 1'b0;
                n_check    = 8'h00;
                n_count    = 16'd0;
            end else begin
                n_in_frame = 1'b1;
                n_check    = new_check;
                n_count    = new_count[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame   <= 1'b0;
            r_check      <= 8'h00;
            r_count      <= 16'd0;
            r_discarding <= 1'b0;
        end else begin
            r_in_frame   <= n_in_frame;
            r_check      <= n_check;
            r_count      <= n_count;
            r_discarding <= n_discarding;
        end
    end

endmodule

// ===== rtl/ifsf_back.sv =====
module ifsf_back import ifsf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_cmd_valid,
    input  t_cmd       i_cmd,
    output logic       o_cmd_pop,
    input  logic       i_pop,
    output logic       o_empty,
    output logic [7:0] o_out_byte,
    output logic       o_end_of_run,
    output logic       o_closing_flag,
    output logic       o_aborted
);

    t_state     r_state;
    t_state     n_state;
    t_cmd       r_cmd;
    logic       r_esc;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_eor;
    logic       r_out_fend;
    logic       r_out_abort;

    logic [7:0] seg_byte;
    logic       seg_stuffed;
    logic       seg_fend;
    logic       seg_abort;
    logic       seg_last;
    logic       need_esc;
    logic       seg_done;
    logic       advance;
    logic       emit;
    logic [7:0] line_byte;

    function automatic t_state start_state(input t_cmd cmd);
        t_state st;
        if (cmd.abort) begin
            st = ST_ABORT;
        end else if (cmd.open) begin
            st = ST_OPEN_FLAG;
        end else begin
            st = ST_DATA;
        end
        return st;
    endfunction

    // per-segment byte and attributes
    always_comb begin
        seg_byte    = 8'h00;
        seg_stuffed = 1'b0;
        seg_fend    = 1'b0;
        seg_abort   = 1'b0;
        seg_last    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
            end
            ST_OPEN_FLAG: begin
                seg_byte = i_cfg.flag_value;
            end
            ST_ADDR: begin
                seg_byte    = i_cfg.address_value;
                seg_stuffed = 1'b1;
            end
            ST_CTRL: begin
                seg_byte    = r_cmd.ctrl;
                seg_stuffed = 1'b1;
            end
            ST_HCHK: begin
                seg_byte    = i_cfg.address_value ^ r_cmd.ctrl;
                seg_stuffed = 1'b1;
            end
            ST_DATA: begin
                seg_byte    = r_cmd.data;
                seg_stuffed = 1'b1;
                seg_last    = !r_cmd.close;
            end
            ST_PCHK: begin
                seg_byte    = r_cmd.check;
                seg_stuffed = 1'b1;
            end
            ST_CLOSE_FLAG: begin
                seg_byte = i_cfg.flag_value;
                seg_fend = 1'b1;
                seg_last = 1'b1;
            end
            ST_ABORT: begin
                seg_abort = 1'b1;
                seg_last  = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign need_esc  = seg_stuffed &&
                       ((seg_byte == i_cfg.flag_value) || (seg_byte == i_cfg.escape_value));
    assign seg_done  = !need_esc || r_esc;
    assign advance   = !r_out_valid || i_pop;
    assign emit      = (r_state != ST_IDLE) && advance;
    assign line_byte = r_esc ? (seg_byte ^ i_cfg.stuff_mask)
                             : (need_esc ? i_cfg.escape_value : seg_byte);

    always_comb begin
        n_state   = r_state;
        o_cmd_pop = 1'b0;
        if (r_state == ST_IDLE) begin
            if (i_cmd_valid) begin
                o_cmd_pop = 1'b1;
                n_state   = start_state(i_cmd);
            end
        end else if (emit && seg_done) begin
            if (seg_last) begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_state   = start_state(i_cmd);
                end else begin
                    n_state = ST_IDLE;
                end
            end else begin
                unique case (r_state)
                    ST_OPEN_FLAG: n_state = ST_ADDR;
                    ST_ADDR:      n_state = ST_CTRL;
                    ST_CTRL:      n_state = ST_HCHK;
                    ST_HCHK:      n_state = ST_DATA;
                    ST_DATA:      n_state = ST_PCHK;
                    ST_PCHK:      n_state = ST_CLOSE_FLAG;
                    default:      n_state = ST_IDLE;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_esc       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_esc <= need_esc && !r_esc;
            end
            if (advance) begin
                r_out_valid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
        if (emit) begin
            r_out_byte  <= line_byte;
            r_out_eor   <= seg_last && seg_done;
            r_out_fend  <= seg_fend;
            r_out_abort <= seg_abort;
        end
    end

    assign o_empty        = !r_out_valid;
    assign o_out_byte     = r_out_byte;
    assign o_end_of_run   = r_out_eor;
    assign o_closing_flag = r_out_fend;
    assign o_aborted      = r_out_abort;

endmodule

// ===== rtl/info_frame_stuffing_framer_core.sv =====
// info frame stuffing framer
// input channel: push/full carries payload bytes with a sequence bit and a
// last-byte marker; an item is taken when push is high and full is low
// result channel: empty/pop presents line bytes oldest first; a result
// leaves when pop is high and empty is low; end_of_run marks the last line
// byte an item causes, closing_flag the closing flag, aborted an oversize frame
// an item makes 1 to 12 line bytes, one per cycle from the back sequencer
// while pop keeps up; for an item taken when idle, the first line byte
// passes the command queue, sequencer state and output register; a payload
// byte in an open frame makes 1 line byte, an escaped one 2, a frame's
// first byte 5 to 9, its last 3 to 5, a one-byte frame 7 to 12, an abort 1
// a command queue of CMD_DEPTH items decouples the input side from the line
// sequencer, so input keeps flowing while a result waits to be taken
// when the receiver stalls, the output register holds, the sequencer halts,
// and full rises once the command queue fills
// reset (synchronous, active low) closes any open frame, clears the check,
// count and discard state, empties the queue and loads the default registers
// registers on the apb port: flag, escape, stuff mask, address, control base,
// max payload; write them only while the block is idle
module info_frame_stuffing_framer_core import ifsf_pkg::*; #(
    parameter int CMD_DEPTH = CMD_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         i_data_byte,
    input  logic               i_seq_bit,
    input  logic               i_last_byte,
    output logic               empty,
    input  logic               pop,
    output logic [7:0]         o_out_byte,
    output logic               o_end_of_run,
    output logic               o_closing_flag,
    output logic               o_aborted,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    `include "info_frame_stuffing_framer_core_defines.svh"

    t_cfg                 r_cfg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_write;
    logic                 in_accept;
    logic                 front_push;
    t_cmd                 front_cmd;
    logic                 cmd_valid;
    t_cmd                 cmd_head;
    logic                 cmd_pop;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[PADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;
    assign in_accept = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.flag_value    <= FLAG_RST;
            r_cfg.escape_value  <= ESCAPE_RST;
            r_cfg.stuff_mask    <= MASK_RST;
            r_cfg.address_value <= ADDRESS_RST;
            r_cfg.control_base  <= CONTROL_RST;
            r_cfg.max_payload   <= MAX_PAY_RST;
        end else if (cfg_write) begin
            unique case (reg_idx)
                REG_FLAG:    r_cfg.flag_value    <= pwdata[7:0];
                REG_ESCAPE:  r_cfg.escape_value  <= pwdata[7:0];
                REG_MASK:    r_cfg.stuff_mask    <= pwdata[7:0];
                REG_ADDRESS: r_cfg.address_value <= pwdata[7:0];
                REG_CONTROL: r_cfg.control_base  <= pwdata[7:0];
                REG_MAX_PAY: r_cfg.max_payload   <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_FLAG:    prdata = {24'h0, r_cfg.flag_value};
            REG_ESCAPE:  prdata = {24'h0, r_cfg.escape_value};
            REG_MASK:    prdata = {24'h0, r_cfg.stuff_mask};
            REG_ADDRESS: prdata = {24'h0, r_cfg.address_value};
            REG_CONTROL: prdata = {24'h0, r_cfg.control_base};
            REG_MAX_PAY: prdata = {16'h0, r_cfg.max_payload};
            default:     prdata = 32'h0;
        endcase
    end

    ifsf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_accept    (in_accept),
        .i_data_byte (i_data_byte),
        .i_seq_bit   (i_seq_bit),
        .i_last_byte (i_last_byte),
        .o_push      (front_push),
        .o_cmd       (front_cmd)
    );

    ifsf_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (cmd_pop),
        .o_valid (cmd_valid),
        .o_cmd   (cmd_head)
    );

    ifsf_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_cmd_valid    (cmd_valid),
        .i_cmd          (cmd_head),
        .o_cmd_pop      (cmd_pop),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_out_byte     (o_out_byte),
        .o_end_of_run   (o_end_of_run),
        .o_closing_flag (o_closing_flag),
        .o_aborted      (o_aborted)
    );

    `IFSF_ASSERT_IMPL(a_abort_ends_run, i_clk, i_rst_n,
        !empty && o_aborted, o_end_of_run && !o_closing_flag && (o_out_byte == 8'h00))
    `IFSF_ASSERT_IMPL(a_close_is_flag, i_clk, i_rst_n,
        !empty && o_closing_flag, o_end_of_run && (o_out_byte == r_cfg.flag_value))
    `IFSF_ASSERT_NEXT(a_hold_while_stalled, i_clk, i_rst_n,
        !empty && !pop, !empty && $stable(o_out_byte) && $stable(o_end_of_run))

endmodule
